@@ rtl/nbm_pkg.sv @@
// Shared constants, types and helpers for the nibble bank mapper.
// No dependencies; the top level, nbm_timer and nbm_checker import this package.

package nbm_pkg;

	// CPU register addresses
	localparam logic [15:0] ADDR_RAM_CTRL = 16'h9002;
	localparam logic [15:0] ADDR_CNT_LOAD = 16'hF000;
	localparam logic [15:0] ADDR_CNT_CTRL = 16'hF001;
	localparam logic [15:0] ADDR_MIRROR   = 16'hF002;

	localparam logic [3:0] PAGE_PRG_LO = 4'h8;
	localparam logic [3:0] PAGE_PRG_HI = 4'h9;
	localparam logic [3:0] PAGE_CHR_LO = 4'hA;
	localparam logic [3:0] PAGE_CHR_HI = 4'hD;
	localparam logic [3:0] PAGE_RELOAD = 4'hE;

	localparam logic [7:0] RAM_ON_KEY = 8'h03;

	// Counter width masks
	localparam logic [15:0] MASK_4  = 16'h000F;
	localparam logic [15:0] MASK_8  = 16'h00FF;
	localparam logic [15:0] MASK_12 = 16'h0FFF;
	localparam logic [15:0] MASK_16 = 16'hFFFF;

	// Item commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Result codes
	localparam logic [1:0] KIND_NONE = 2'd0;
	localparam logic [1:0] KIND_PRG  = 2'd1;
	localparam logic [1:0] KIND_CHR  = 2'd2;

	localparam logic [1:0] MIRROR_HORZ   = 2'd0;
	localparam logic [1:0] MIRROR_VERT   = 2'd1;
	localparam logic [1:0] MIRROR_SINGLE = 2'd2;

	// Configuration register indexes
	localparam logic CFG_PRG_MAX = 1'b0;
	localparam logic CFG_CHR_MAX = 1'b1;

	localparam logic [7:0] MAX_BANK_RESET = 8'hFF;

	// Timer operations decoded from one item
	typedef struct packed {
		logic       tick;
		logic       load;
		logic       ctrl;
		logic       rld_we;
		logic [1:0] rld_sel;
	} timer_cmd_t;

	// Replace one nibble of a bank number, then fold it under the maximum.
	function automatic logic [7:0] merge_nibble(
		input logic [7:0] old_bank,
		input logic [7:0] wdata,
		input logic       high,
		input logic [7:0] max_bank
	);
		logic [7:0] v;
		begin
			v = high ? {wdata[3:0], old_bank[3:0]} : {old_bank[7:4], wdata[3:0]};
			if (v > max_bank) begin
				v = v & max_bank;
			end
			return v;
		end
	endfunction

endpackage

@@ rtl/nbm_in_if.sv @@
// Input item channel: valid/ready handshake with a bus write or tick word.
// Depends on nothing.

interface nbm_in_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [15:0] address;
	logic [7:0]  data;

	modport source (output valid, output command, output address, output data, input ready);
	modport sink   (input valid, input command, input address, input data, output ready);
endinterface

@@ rtl/nbm_out_if.sv @@
// Result channel: valid/ready handshake with the mapper status word.
// Depends on nothing.

interface nbm_out_if;
	logic       valid;
	logic       ready;
	logic       irq_line;
	logic [1:0] mirror_mode;
	logic       ram_enabled;
	logic [1:0] update_kind;
	logic [2:0] update_slot;
	logic [7:0] update_bank;

	modport source (output valid, output irq_line, output mirror_mode, output ram_enabled,
		output update_kind, output update_slot, output update_bank, input ready);
	modport sink   (input valid, input irq_line, input mirror_mode, input ram_enabled,
		input update_kind, input update_slot, input update_bank, output ready);
endinterface

@@ rtl/nbm_cfg_if.sv @@
// Configuration write channel: valid/ready, register index and write data.
// Depends on nothing.

interface nbm_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink   (input valid, input index, input wdata, output ready);
endinterface

@@ rtl/nibble_bank_mapper_with_irq_counter.sv @@
// Top level of the nibble bank mapper with its interrupt counter.
// Depends on nbm_pkg, the nbm_in_if / nbm_out_if / nbm_cfg_if interfaces and nbm_timer.

// One word in, one word out: every accepted bus write or tick gives exactly one result
// word. Throughput is one word per clock while the result side does not stall. A word
// passes the input register (_s1) and then the result register (_s2), with all decode,
// nibble merge, bank clamp and counter update done in the single pass between them. The
// result register holds a stalled word while the input register keeps taking words as
// long as the result side drains. The configuration port (register 0: highest program
// bank, register 1: highest pattern bank, both reset to 255) is always ready; write it
// only while the block is idle. There is no clearing pass after reset.

module nibble_bank_mapper_with_irq_counter
	import nbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	nbm_in_if.sink     item,
	nbm_out_if.source  result,
	nbm_cfg_if.sink    cfg
);

	// configuration
	logic [7:0] prg_max_q;
	logic [7:0] chr_max_q;

	// input register
	logic        valid_s1;
	logic        command_s1;
	logic [15:0] address_s1;
	logic [7:0]  data_s1;

	// result register
	logic       valid_s2;
	logic       irq_s2;
	logic [1:0] mirror_s2;
	logic       ram_s2;
	logic [1:0] kind_s2;
	logic [2:0] slot_s2;
	logic [7:0] bank_s2;

	// mapper state
	logic [7:0] prg_bank_q [3];
	logic [7:0] chr_bank_q [8];
	logic [1:0] mirror_q;
	logic       ram_on_q;

	logic       advance;
	logic       is_write;
	logic [3:0] page;
	logic       low_small;
	logic       prg_hit;
	logic       chr_hit;
	logic [1:0] prg_slot;
	logic [3:0] chr_pair;
	logic [2:0] chr_slot;
	logic [7:0] prg_new;
	logic [7:0] chr_new;
	logic       ram_set;
	logic       mirror_we;
	logic [1:0] mirror_new;
	logic [1:0] kind_d;
	logic [2:0] slot_d;
	logic [7:0] bank_d;
	logic       irq_next;
	timer_cmd_t tcmd;

	// Handshake: move stage 1 on when the result register is empty or being drained.
	assign advance    = valid_s1 && (!valid_s2 || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign cfg.ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_max_q <= MAX_BANK_RESET;
			chr_max_q <= MAX_BANK_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_PRG_MAX: prg_max_q <= cfg.wdata;
				CFG_CHR_MAX: chr_max_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	// Capture the incoming word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			command_s1 <= item.command;
			address_s1 <= item.address;
			data_s1    <= item.data;
		end
	end

	// Address decode. Each bank register pair sits at offsets 0..3 of its page;
	// the low bit picks the nibble and bit 1 picks the slot within the page.
	assign is_write  = (command_s1 == CMD_WRITE);
	assign page      = address_s1[15:12];
	assign low_small = (address_s1[11:2] == 10'd0);

	// Program page 9 has only one slot; 0x9002 is the work RAM key instead.
	assign prg_hit  = is_write && low_small &&
		((page == PAGE_PRG_LO) || ((page == PAGE_PRG_HI) && !address_s1[1]));
	assign prg_slot = (page == PAGE_PRG_LO) ? {1'b0, address_s1[1]} : 2'd2;

	assign chr_hit  = is_write && low_small && (page >= PAGE_CHR_LO) && (page <= PAGE_CHR_HI);
	assign chr_pair = page - PAGE_CHR_LO;
	assign chr_slot = {chr_pair[1:0], address_s1[1]};

	assign prg_new = merge_nibble(prg_bank_q[prg_slot], data_s1, address_s1[0], prg_max_q);
	assign chr_new = merge_nibble(chr_bank_q[chr_slot], data_s1, address_s1[0], chr_max_q);

	// Work RAM only ever switches on, and only with the right key.
	assign ram_set   = is_write && (address_s1 == ADDR_RAM_CTRL) && (data_s1 == RAM_ON_KEY);
	assign mirror_we = is_write && (address_s1 == ADDR_MIRROR);

	always_comb begin
		if (data_s1[1]) begin
			mirror_new = MIRROR_SINGLE;
		end else if (data_s1[0]) begin
			mirror_new = MIRROR_VERT;
		end else begin
			mirror_new = MIRROR_HORZ;
		end
	end

	// Report which bank moved; all zero when none did.
	always_comb begin
		kind_d = KIND_NONE;
		slot_d = 3'd0;
		bank_d = 8'd0;
		if (prg_hit) begin
			kind_d = KIND_PRG;
			slot_d = {1'b0, prg_slot};
			bank_d = prg_new;
		end else if (chr_hit) begin
			kind_d = KIND_CHR;
			slot_d = chr_slot;
			bank_d = chr_new;
		end
	end

	assign tcmd.tick    = (command_s1 == CMD_TICK);
	assign tcmd.load    = is_write && (address_s1 == ADDR_CNT_LOAD);
	assign tcmd.ctrl    = is_write && (address_s1 == ADDR_CNT_CTRL);
	assign tcmd.rld_we  = is_write && low_small && (page == PAGE_RELOAD);
	assign tcmd.rld_sel = address_s1[1:0];

	nbm_timer u_timer (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (advance),
		.cmd      (tcmd),
		.data     (data_s1),
		.irq_next (irq_next)
	);

	// Commit the word's effect on the mapper state as it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				prg_bank_q[i] <= 8'(i);
			end
			for (int i = 0; i < 8; i++) begin
				chr_bank_q[i] <= 8'(i);
			end
			mirror_q <= MIRROR_HORZ;
			ram_on_q <= 1'b0;
		end else if (advance) begin
			if (prg_hit) begin
				prg_bank_q[prg_slot] <= prg_new;
			end
			if (chr_hit) begin
				chr_bank_q[chr_slot] <= chr_new;
			end
			if (mirror_we) begin
				mirror_q <= mirror_new;
			end
			if (ram_set) begin
				ram_on_q <= 1'b1;
			end
		end
	end

	// Result register: load on advance, drop when taken, otherwise hold.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			irq_s2    <= irq_next;
			mirror_s2 <= mirror_we ? mirror_new : mirror_q;
			ram_s2    <= ram_on_q | ram_set;
			kind_s2   <= kind_d;
			slot_s2   <= slot_d;
			bank_s2   <= bank_d;
		end
	end

	assign result.valid       = valid_s2;
	assign result.irq_line    = irq_s2;
	assign result.mirror_mode = mirror_s2;
	assign result.ram_enabled = ram_s2;
	assign result.update_kind = kind_s2;
	assign result.update_slot = slot_s2;
	assign result.update_bank = bank_s2;

endmodule

@@ rtl/nbm_timer.sv @@
// Interrupt down-counter: reload value, counter, width mask and one-tick delay.
// Depends on nbm_pkg (timer_cmd_t, width masks).

module nbm_timer
	import nbm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  timer_cmd_t cmd,
	input  logic [7:0] data,
	output logic       irq_next
);

	logic [15:0] reload_q, reload_d;
	logic [15:0] count_q, count_d;
	logic [15:0] mask_q, mask_d;
	logic        enable_q, enable_d;
	logic        armed_q, armed_d;
	logic        pending_q, pending_d;
	logic [15:0] count_dec;

	assign count_dec = count_q - 16'd1;
	assign irq_next  = pending_d;

	always_comb begin
		reload_d  = reload_q;
		count_d   = count_q;
		mask_d    = mask_q;
		enable_d  = enable_q;
		armed_d   = armed_q;
		pending_d = pending_q;
		if (step) begin
			if (cmd.tick && enable_q) begin
				// fire the delayed interrupt first, then advance the counter
				if (armed_q) begin
					pending_d = 1'b1;
					armed_d   = 1'b0;
				end
				if ((count_q & mask_q) != 16'd0) begin
					count_d = count_dec;
					if ((count_dec & mask_q) == 16'd0) begin
						armed_d = 1'b1;
					end
				end
			end
			if (cmd.rld_we) begin
				reload_d[{cmd.rld_sel, 2'b00} +: 4] = data[3:0];
			end
			if (cmd.load) begin
				count_d   = reload_q;
				pending_d = 1'b0;
			end
			if (cmd.ctrl) begin
				enable_d = data[0];
				if (data[3]) begin
					mask_d = MASK_4;
				end else if (data[2]) begin
					mask_d = MASK_8;
				end else if (data[1]) begin
					mask_d = MASK_12;
				end else begin
					mask_d = MASK_16;
				end
				pending_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reload_q  <= 16'd0;
			count_q   <= 16'd0;
			mask_q    <= MASK_16;
			enable_q  <= 1'b0;
			armed_q   <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			reload_q  <= reload_d;
			count_q   <= count_d;
			mask_q    <= mask_d;
			enable_q  <= enable_d;
			armed_q   <= armed_d;
			pending_q <= pending_d;
		end
	end

endmodule

@@ rtl/nbm_checker.sv @@
// Port-level checks for the nibble bank mapper, attached to the top level by bind.
// Depends on nbm_pkg (result codes).

module nbm_checker
	import nbm_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [1:0] mirror_mode,
	input logic       ram_enabled,
	input logic [1:0] update_kind,
	input logic [2:0] update_slot,
	input logic [7:0] update_bank
);

	// A stalled word holds its bank, slot and kind.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(update_bank) &&
		$stable(update_slot) && $stable(update_kind))
		else $error("stalled result word changed");

	// No bank change reports an all-zero slot and bank.
	a_no_update_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (update_kind == KIND_NONE) |-> (update_slot == 3'd0) && (update_bank == 8'd0))
		else $error("idle update carries slot or bank");

	// Program updates only touch slots 0..2.
	a_prg_slot: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (update_kind == KIND_PRG) |-> (update_slot <= 3'd2))
		else $error("program update on a slot beyond 2");

	// Work RAM never switches off again.
	a_ram_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && ram_enabled ##1 res_valid |-> ram_enabled)
		else $error("work RAM enable dropped");

	// Mirroring takes one of its three codes only.
	a_mirror_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (mirror_mode == MIRROR_HORZ) || (mirror_mode == MIRROR_VERT) ||
		(mirror_mode == MIRROR_SINGLE))
		else $error("mirror mode out of range");

endmodule

bind nibble_bank_mapper_with_irq_counter nbm_checker u_nbm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.res_valid   (result.valid),
	.res_ready   (result.ready),
	.mirror_mode (result.mirror_mode),
	.ram_enabled (result.ram_enabled),
	.update_kind (result.update_kind),
	.update_slot (result.update_slot),
	.update_bank (result.update_bank)
);
